[src/dtc_pkg.sv]
package dtc_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int TABLE_LOG2     = 6;

    localparam int PL2_W    = 3;
    localparam int KEEP_W   = 7;
    localparam int FILL_W   = 7;
    localparam int SAMPLE_W = 16;
    localparam int VALUE_W  = 31;
    localparam int TW_W     = 16;
    localparam int WORD_W   = 32;
    localparam int ANGLE_W  = 8;

    localparam logic [PL2_W-1:0]  PL2_RESET  = 3'd6;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd64;

    // Register indexes on the configuration port.
    localparam logic REG_POINTS_LOG2 = 1'b0;
    localparam logic REG_KEEP_COUNT  = 1'b1;

    localparam logic signed [33:0] VALUE_MAX = 34'sd1073741823;
    localparam logic signed [33:0] VALUE_MIN = -34'sd1073741824;

    typedef logic signed [TW_W-1:0] t_tw;

    // sin(2*pi*m/256) in Q1.15 for m = 0..64.
    function automatic t_tw quarter_sine(input logic [6:0] m);
        t_tw v;
        unique case (m)
            7'd0:  v = 16'sd0;     7'd1:  v = 16'sd804;   7'd2:  v = 16'sd1608;
            7'd3:  v = 16'sd2411;  7'd4:  v = 16'sd3212;  7'd5:  v = 16'sd4011;
            7'd6:  v = 16'sd4808;  7'd7:  v = 16'sd5602;  7'd8:  v = 16'sd6393;
            7'd9:  v = 16'sd7180;  7'd10: v = 16'sd7962;  7'd11: v = 16'sd8740;
            7'd12: v = 16'sd9512;  7'd13: v = 16'sd10279; 7'd14: v = 16'sd11039;
            7'd15: v = 16'sd11793; 7'd16: v = 16'sd12540; 7'd17: v = 16'sd13279;
            7'd18: v = 16'sd14010; 7'd19: v = 16'sd14733; 7'd20: v = 16'sd15447;
            7'd21: v = 16'sd16151; 7'd22: v = 16'sd16846; 7'd23: v = 16'sd17531;
            7'd24: v = 16'sd18205; 7'd25: v = 16'sd18868; 7'd26: v = 16'sd19520;
            7'd27: v = 16'sd20160; 7'd28: v = 16'sd20788; 7'd29: v = 16'sd21403;
            7'd30: v = 16'sd22006; 7'd31: v = 16'sd22595; 7'd32: v = 16'sd23170;
            7'd33: v = 16'sd23732; 7'd34: v = 16'sd24279; 7'd35: v = 16'sd24812;
            7'd36: v = 16'sd25330; 7'd37: v = 16'sd25833; 7'd38: v = 16'sd26320;
            7'd39: v = 16'sd26791; 7'd40: v = 16'sd27246; 7'd41: v = 16'sd27684;
            7'd42: v = 16'sd28106; 7'd43: v = 16'sd28511; 7'd44: v = 16'sd28899;
            7'd45: v = 16'sd29269; 7'd46: v = 16'sd29622; 7'd47: v = 16'sd29957;
            7'd48: v = 16'sd30274; 7'd49: v = 16'sd30572; 7'd50: v = 16'sd30853;
            7'd51: v = 16'sd31114; 7'd52: v = 16'sd31357; 7'd53: v = 16'sd31581;
            7'd54: v = 16'sd31786; 7'd55: v = 16'sd31972; 7'd56: v = 16'sd32138;
            7'd57: v = 16'sd32286; 7'd58: v = 16'sd32413; 7'd59: v = 16'sd32522;
            7'd60: v = 16'sd32610; 7'd61: v = 16'sd32679; 7'd62: v = 16'sd32729;
            7'd63: v = 16'sd32758; 7'd64: v = 16'sd32767;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    // Angles are in units of 2*pi/256; only the lower half turn is used.
    function automatic t_tw tw_sin(input logic [ANGLE_W-1:0] idx);
        logic [6:0] i;
        i = idx[6:0];
        return (i <= 7'd64) ? quarter_sine(i) : quarter_sine(7'(8'd128 - {1'b0, i}));
    endfunction

    function automatic t_tw tw_cos(input logic [ANGLE_W-1:0] idx);
        logic [6:0] i;
        i = idx[6:0];
        return (i <= 7'd64) ? quarter_sine(7'd64 - i) : -quarter_sine(i - 7'd64);
    endfunction

endpackage

[src/dtc_ram.sv]
module dtc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[src/dct_truncating_compressor.sv]
// Truncating DCT-II compressor.
// Samples arrive on the input channel (i_valid / o_stall), one transfer per
// sample. Once 2^points_log2 samples are in, the block reorders them into the
// work memory, runs a radix-2 FFT with one butterfly at a time, rotates each
// bin and sends keep_count-1 coefficients followed by one item with last set
// that carries the point count, on the output channel (o_valid / i_stall).
// If keep_count is below 2 or above the block size, one item with bad_size
// and last set is sent instead.
// Samples are taken one per cycle while the block collects. After the final
// sample of a block the input stalls through the copy, the butterflies (each
// butterfly reads, multiplies, rounds and writes back through the single port
// pair of the work memory) and the emission of the coefficients.
// The output holds its item in a register; a stall from the receiver freezes
// the item and the emission sequence until the transfer completes. Once the
// size item is loaded the next block may begin collecting at once.
// Reset (synchronous, active low) clears the fill count and the sequencer and
// sets points_log2 to 6 and keep_count to 64. The memories are not cleared.
module dct_truncating_compressor #(
    parameter int MAX_POINTS = dtc_pkg::MAX_POINTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [dtc_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [dtc_pkg::VALUE_W-1:0]   o_value,
    output logic                                 o_last,
    output logic                                 o_bad_size,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import dtc_pkg::*;

    localparam int AW   = $clog2(MAX_POINTS);
    localparam int MAXL = $clog2(MAX_POINTS + 1) - 1;
    localparam int TW2  = 2 * WORD_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ERR   = 4'd1;
    localparam logic [3:0] S_COPY  = 4'd2;
    localparam logic [3:0] S_BF_A  = 4'd3;
    localparam logic [3:0] S_BF_B  = 4'd4;
    localparam logic [3:0] S_BF_M  = 4'd5;
    localparam logic [3:0] S_BF_T  = 4'd6;
    localparam logic [3:0] S_BF_WA = 4'd7;
    localparam logic [3:0] S_BF_WB = 4'd8;
    localparam logic [3:0] S_E_RD  = 4'd9;
    localparam logic [3:0] S_E_M   = 4'd10;
    localparam logic [3:0] S_E_S   = 4'd11;
    localparam logic [3:0] S_E_O   = 4'd12;
    localparam logic [3:0] S_E_LST = 4'd13;

    // Configuration registers.
    logic [PL2_W-1:0]  r_points_log2;
    logic [KEEP_W-1:0] r_keep_count;

    // Sequencer state.
    logic [3:0]        r_state;
    logic [FILL_W-1:0] r_fill;
    logic [PL2_W-1:0]  r_lg;
    logic [FILL_W-1:0] r_cnt;
    logic [AW-2:0]     r_t;
    logic [PL2_W-1:0]  r_stage;
    logic [FILL_W-1:0] r_k;
    logic [AW-1:0]     r_wa;
    logic [ANGLE_W-1:0] r_tw;

    // Datapath registers.
    logic signed [WORD_W-1:0] r_ar, r_ai;
    logic signed [47:0]       r_p0, r_p1, r_p2, r_p3;
    logic signed [33:0]       r_tr, r_ti;

    // Output register.
    logic                      r_o_valid;
    logic [VALUE_W-1:0]        r_o_value;
    logic                      r_o_last;
    logic                      r_o_bad;

    logic cfg_wr;
    logic in_acc;
    logic out_free;
    logic out_load;

    logic [PL2_W-1:0]  lg_cfg;
    logic [FILL_W-1:0] n_cfg;
    logic [FILL_W-1:0] n_blk;
    logic [FILL_W-1:0] fill_inc;

    logic              s_we;
    logic [SAMPLE_W-1:0] s_rdata;
    logic              w_we;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [TW2-1:0]    w_wdata, w_rdata;

    logic [AW-1:0]     bf_a, bf_b, bf_j, bf_t, half_mask;
    logic [ANGLE_W-1:0] bf_tw, e_tw;
    logic [AW-1:0]     perm_addr, perm_rev;
    logic [FILL_W-1:0] perm_i;
    logic [AW-2:0]     t_last;

    logic signed [WORD_W-1:0] x_re, x_im;
    t_tw tw_c, tw_s;
    logic signed [48:0] sum_r, sum_i;
    logic [WORD_W-1:0]  samp_word;
    logic [VALUE_W-1:0] sat_value;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_KEEP_COUNT) begin
            prdata = {25'd0, r_keep_count};
        end else begin
            prdata = {29'd0, r_points_log2};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points_log2 <= PL2_RESET;
            r_keep_count  <= KEEP_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_POINTS_LOG2) begin
                r_points_log2 <= pwdata[PL2_W-1:0];
            end else begin
                r_keep_count <= pwdata[KEEP_W-1:0];
            end
        end
    end

    // Block size in force: zero acts as one, large values clamp to the memory.
    always_comb begin
        if (r_points_log2 == '0) begin
            lg_cfg = PL2_W'(1);
        end else if (r_points_log2 > PL2_W'(MAXL)) begin
            lg_cfg = PL2_W'(MAXL);
        end else begin
            lg_cfg = r_points_log2;
        end
    end

    assign n_cfg    = FILL_W'(1) << lg_cfg;
    assign n_blk    = FILL_W'(1) << r_lg;
    assign fill_inc = r_fill + FILL_W'(1);

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;

    // A new item is loaded into the output register in this cycle.
    assign out_load = out_free &&
                      (r_state == S_ERR || r_state == S_E_O || r_state == S_E_LST);

    // Sample memory holds raw samples in arrival order.
    assign s_we = in_acc && (r_fill < FILL_W'(MAX_POINTS));

    dtc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_POINTS)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata (i_sample),
        .i_raddr (r_cnt[AW-1:0]),
        .o_rdata (s_rdata)
    );

    // Reordering: even samples first, odd samples reversed, then bit reversal
    // over log2(N) bits for the decimation-in-time FFT.
    always_comb begin
        if (r_cnt[0]) begin
            perm_i = n_blk - ((r_cnt + FILL_W'(1)) >> 1);
        end else begin
            perm_i = r_cnt >> 1;
        end
        for (int b = 0; b < AW; b++) begin
            perm_rev[b] = perm_i[AW-1-b];
        end
        perm_addr = perm_rev >> (PL2_W'(AW) - r_lg);
    end

    // Butterfly addressing for stage r_stage (span 2^r_stage).
    always_comb begin
        bf_t      = {1'b0, r_t};
        half_mask = (AW'(1) << (r_stage - PL2_W'(1))) - AW'(1);
        bf_j      = bf_t & half_mask;
        bf_a      = ((bf_t >> (r_stage - PL2_W'(1))) << r_stage) | bf_j;
        bf_b      = bf_a | (AW'(1) << (r_stage - PL2_W'(1)));
        bf_tw     = ANGLE_W'(bf_j) << (PL2_W'(ANGLE_W) - r_stage);
        e_tw      = ANGLE_W'(r_k) << (PL2_W'(TABLE_LOG2) - r_lg);
        t_last    = (AW-1)'((n_blk >> 1) - FILL_W'(1));
    end

    // Work memory: real part in the upper half, imaginary in the lower.
    assign samp_word = {{(WORD_W-SAMPLE_W-8){s_rdata[SAMPLE_W-1]}}, s_rdata, 8'h00};

    always_comb begin
        w_we    = 1'b0;
        w_waddr = bf_a;
        w_wdata = {r_ar + r_tr[WORD_W-1:0], r_ai + r_ti[WORD_W-1:0]};
        w_raddr = bf_a;
        unique case (r_state)
            S_COPY: begin
                w_we    = (r_cnt != '0);
                w_waddr = r_wa;
                w_wdata = {samp_word, {WORD_W{1'b0}}};
            end
            S_BF_B: begin
                w_raddr = bf_b;
            end
            S_BF_WA: begin
                w_we = 1'b1;
            end
            S_BF_WB: begin
                w_we    = 1'b1;
                w_waddr = bf_b;
                w_wdata = {r_ar - r_tr[WORD_W-1:0], r_ai - r_ti[WORD_W-1:0]};
            end
            S_E_RD: begin
                w_raddr = r_k[AW-1:0];
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    dtc_ram #(
        .WIDTH (TW2),
        .DEPTH (MAX_POINTS)
    ) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Shared complex multiply: products are registered, then summed and
    // rounded to nearest (half up) in the next cycle.
    assign x_re  = w_rdata[TW2-1:WORD_W];
    assign x_im  = w_rdata[WORD_W-1:0];
    assign tw_c  = tw_cos(r_tw);
    assign tw_s  = tw_sin(r_tw);
    assign sum_r = 49'(r_p0) + 49'(r_p1) + 49'sd16384;
    assign sum_i = 49'(r_p2) - 49'(r_p3) + 49'sd16384;

    always_comb begin
        if (r_tr > VALUE_MAX) begin
            sat_value = VALUE_MAX[VALUE_W-1:0];
        end else if (r_tr < VALUE_MIN) begin
            sat_value = VALUE_MIN[VALUE_W-1:0];
        end else begin
            sat_value = r_tr[VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_BF_B) begin
            r_ar <= x_re;
            r_ai <= x_im;
        end
        if (r_state == S_BF_M || r_state == S_E_M) begin
            r_p0 <= x_re * tw_c;
            r_p1 <= x_im * tw_s;
            r_p2 <= x_im * tw_c;
            r_p3 <= x_re * tw_s;
        end
        if (r_state == S_BF_T || r_state == S_E_S) begin
            r_tr <= 34'(sum_r >>> 15);
            r_ti <= 34'(sum_i >>> 15);
        end
        if (r_state == S_COPY) begin
            r_wa <= perm_addr;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_lg      <= PL2_W'(1);
            r_cnt     <= '0;
            r_t       <= '0;
            r_stage   <= PL2_W'(1);
            r_k       <= '0;
            r_tw      <= '0;
            r_o_valid <= 1'b0;
            r_o_value <= '0;
            r_o_last  <= 1'b0;
            r_o_bad   <= 1'b0;
        end else begin
            if (r_o_valid && !i_stall && !out_load) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (fill_inc >= n_cfg) begin
                            r_fill <= '0;
                            r_lg   <= lg_cfg;
                            r_cnt  <= '0;
                            if (r_keep_count < KEEP_W'(2) || r_keep_count > n_cfg) begin
                                r_state <= S_ERR;
                            end else begin
                                r_state <= S_COPY;
                            end
                        end else begin
                            r_fill <= fill_inc;
                        end
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_value <= '0;
                        r_o_last  <= 1'b1;
                        r_o_bad   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                S_COPY: begin
                    r_cnt <= r_cnt + FILL_W'(1);
                    if (r_cnt == n_blk) begin
                        r_stage <= PL2_W'(1);
                        r_t     <= '0;
                        r_state <= S_BF_A;
                    end
                end
                S_BF_A: begin
                    r_tw    <= bf_tw;
                    r_state <= S_BF_B;
                end
                S_BF_B: begin
                    r_state <= S_BF_M;
                end
                S_BF_M: begin
                    r_state <= S_BF_T;
                end
                S_BF_T: begin
                    r_state <= S_BF_WA;
                end
                S_BF_WA: begin
                    r_state <= S_BF_WB;
                end
                S_BF_WB: begin
                    if (r_t == t_last) begin
                        r_t <= '0;
                        if (r_stage == r_lg) begin
                            r_k     <= '0;
                            r_state <= S_E_RD;
                        end else begin
                            r_stage <= r_stage + PL2_W'(1);
                            r_state <= S_BF_A;
                        end
                    end else begin
                        r_t     <= r_t + (AW-1)'(1);
                        r_state <= S_BF_A;
                    end
                end
                S_E_RD: begin
                    r_tw <= e_tw;
                    if (r_k + FILL_W'(1) < r_keep_count) begin
                        r_state <= S_E_M;
                    end else begin
                        r_state <= S_E_LST;
                    end
                end
                S_E_M: begin
                    r_state <= S_E_S;
                end
                S_E_S: begin
                    r_state <= S_E_O;
                end
                S_E_O: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_value <= sat_value;
                        r_o_last  <= 1'b0;
                        r_o_bad   <= 1'b0;
                        r_k       <= r_k + FILL_W'(1);
                        r_state   <= S_E_RD;
                    end
                end
                S_E_LST: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_value <= VALUE_W'(n_blk);
                        r_o_last  <= 1'b1;
                        r_o_bad   <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid    = r_o_valid;
    assign o_value    = r_o_value;
    assign o_last     = r_o_last;
    assign o_bad_size = r_o_bad;

`ifndef SYNTHESIS
    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_size) |-> o_last)
        else $error("bad_size item without last");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_fill < FILL_W'(MAX_POINTS)))
        else $error("fill count beyond memory depth");

    a_bf_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BF_A) |-> ((bf_a < bf_b) && (bf_b < n_blk[AW:0])))
        else $error("butterfly addresses out of order");

    a_emit_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_E_O && out_free) |=> (o_valid && !o_last))
        else $error("coefficient not presented after load");
`endif

endmodule
